@@ hdl/brt_pkg.sv @@
// brt_pkg: shared types, opcodes and constants for the block cipher round transforms
// no dependencies; used by brt_lane, brt_merge and the core top level
`timescale 1ns / 1ps

package brt_pkg;

    // bytes of the block that the transforms act on (2..16), upper bytes pass through
    localparam int BLOCK_BYTES  = 16;
    localparam int MAX_BYTES    = 16;
    localparam int DIFF_LEVELS  = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

    localparam int PERM_STEP    = 5;
    localparam int ROT_PERIOD   = 7;

    localparam logic [7:0] SBOX_MUL     = 8'd73;
    localparam logic [7:0] SBOX_ADD     = 8'd41;
    localparam logic [7:0] INV_SBOX_MUL = 8'd249;

    typedef enum logic [3:0] {
        OP_KEY_XOR     = 4'd0,
        OP_SBOX        = 4'd1,
        OP_INV_SBOX    = 4'd2,
        OP_ROTL        = 4'd3,
        OP_ROTR        = 4'd4,
        OP_PERM        = 4'd5,
        OP_INV_PERM    = 4'd6,
        OP_DIFFUSE     = 4'd7,
        OP_INV_DIFFUSE = 4'd8
    } t_opcode;

    typedef logic [MAX_BYTES-1:0][7:0] t_blk;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [63:0] block_lo;
        logic [63:0] block_hi;
        logic [63:0] key_lo;
        logic [63:0] key_hi;
    } t_req;

    typedef struct packed {
        logic [63:0] result_lo;
        logic [63:0] result_hi;
        logic        bad_opcode;
    } t_rsp;

    // source byte of the forward permutation for destination dst
    function automatic int perm_src(input int dst);
        return (PERM_STEP * dst) % BLOCK_BYTES;
    endfunction

    // last source that the inverse permutation writes into dst, -1 if none
    function automatic int inv_perm_src(input int dst);
        int src;
        src = -1;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            if ((PERM_STEP * i) % BLOCK_BYTES == dst) begin
                src = i;
            end
        end
        return src;
    endfunction

endpackage

@@ hdl/brt_lane.sv @@
// brt_lane: per-byte transforms (key xor, affine sbox and inverse, rotates)
// depends on brt_pkg
`timescale 1ns / 1ps

module brt_lane (
    input  brt_pkg::t_opcode i_op,
    input  logic [7:0]       i_byte,
    input  logic [7:0]       i_key,
    input  logic [2:0]       i_rot,
    output logic [7:0]       o_byte
);

    logic [15:0] dbl;
    logic [15:0] dbl_l;
    logic [15:0] dbl_r;
    logic [7:0]  sbox;
    logic [7:0]  unbias;
    logic [7:0]  sbox_rev;

    assign dbl    = {i_byte, i_byte};
    assign dbl_l  = dbl << i_rot;
    assign dbl_r  = dbl >> i_rot;

    // products are taken mod 256 by the 8-bit context
    assign sbox     = 8'(brt_pkg::SBOX_MUL * i_byte) + brt_pkg::SBOX_ADD;
    assign unbias   = i_byte - brt_pkg::SBOX_ADD;
    assign sbox_rev = 8'(brt_pkg::INV_SBOX_MUL * unbias);

    always_comb begin
        case (i_op)
            brt_pkg::OP_KEY_XOR:  o_byte = i_byte ^ i_key;
            brt_pkg::OP_SBOX:     o_byte = sbox;
            brt_pkg::OP_INV_SBOX: o_byte = sbox_rev;
            brt_pkg::OP_ROTL:     o_byte = dbl_l[15:8];
            brt_pkg::OP_ROTR:     o_byte = dbl_r[7:0];
            default:              o_byte = i_byte;
        endcase
    end

endmodule

@@ hdl/brt_merge.sv @@
// brt_merge: combines lane results with the cross-byte transforms
// (permutations and prefix-xor diffusion) and flags bad opcodes; depends on brt_pkg
`timescale 1ns / 1ps

module brt_merge (
    input  logic [3:0]    i_opcode,
    input  brt_pkg::t_blk i_orig,
    input  brt_pkg::t_blk i_lane,
    output brt_pkg::t_rsp o_rsp
);

    brt_pkg::t_blk perm;
    brt_pkg::t_blk inv_perm;
    brt_pkg::t_blk inv_diff;
    brt_pkg::t_blk diff;
    brt_pkg::t_blk lvl [brt_pkg::DIFF_LEVELS+1];
    brt_pkg::t_blk sel;
    brt_pkg::t_opcode op;
    logic bad;

    assign op = brt_pkg::t_opcode'(i_opcode);

    // byte routing fixed at elaboration
    for (genvar g = 0; g < brt_pkg::MAX_BYTES; g++) begin : g_route
        if (g < brt_pkg::BLOCK_BYTES) begin : g_act
            localparam int PSRC = brt_pkg::perm_src(g);
            localparam int ISRC = brt_pkg::inv_perm_src(g);
            assign perm[g] = i_orig[PSRC];
            if (ISRC >= 0) begin : g_inv
                assign inv_perm[g] = i_orig[ISRC];
            end else begin : g_keep
                assign inv_perm[g] = i_orig[g];
            end
            if (g > 0) begin : g_idiff
                assign inv_diff[g] = i_orig[g] ^ i_orig[g-1];
            end else begin : g_idiff0
                assign inv_diff[g] = i_orig[g];
            end
        end else begin : g_pass
            assign perm[g]     = i_orig[g];
            assign inv_perm[g] = i_orig[g];
            assign inv_diff[g] = i_orig[g];
        end
    end

    // prefix xor as a log-depth scan over the active bytes
    always_comb begin
        lvl[0] = i_orig;
        for (int l = 0; l < brt_pkg::DIFF_LEVELS; l++) begin
            lvl[l+1] = lvl[l];
            for (int j = 0; j < brt_pkg::BLOCK_BYTES; j++) begin
                if (j >= (1 << l)) begin
                    lvl[l+1][j] = lvl[l][j] ^ lvl[l][j - (1 << l)];
                end
            end
        end
        diff = lvl[brt_pkg::DIFF_LEVELS];
    end

    always_comb begin
        bad = 1'b0;
        case (op)
            brt_pkg::OP_KEY_XOR,
            brt_pkg::OP_SBOX,
            brt_pkg::OP_INV_SBOX,
            brt_pkg::OP_ROTL,
            brt_pkg::OP_ROTR:        sel = i_lane;
            brt_pkg::OP_PERM:        sel = perm;
            brt_pkg::OP_INV_PERM:    sel = inv_perm;
            brt_pkg::OP_DIFFUSE:     sel = diff;
            brt_pkg::OP_INV_DIFFUSE: sel = inv_diff;
            default: begin
                sel = i_orig;
                bad = 1'b1;
            end
        endcase
    end

    assign o_rsp.result_lo  = sel[7:0];
    assign o_rsp.result_hi  = sel[15:8];
    assign o_rsp.bad_opcode = bad;

endmodule

@@ hdl/block_cipher_round_transforms_core.sv @@
// block_cipher_round_transforms_core: top level, byte lanes plus merge stage
// and one result register; depends on brt_pkg, brt_lane and brt_merge
`timescale 1ns / 1ps

// Applies one of nine cipher round transforms to a 16-byte block. A request is
// taken on any clock edge where start is high; busy is always low, so a new
// request may be issued every cycle. The result shows on o_rsp with o_done high
// for exactly one cycle, the cycle right after the request; throughput is one block
// per clock, set by the single output register behind the byte lanes and the merge
// stage. The receiver cannot hold a result off, so it must take o_rsp whenever
// o_done is high. Opcodes above 8 return the block unchanged with bad_opcode set.
module block_cipher_round_transforms_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  brt_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output brt_pkg::t_rsp o_rsp
);

    brt_pkg::t_blk    blk;
    brt_pkg::t_blk    key;
    brt_pkg::t_blk    lane_out;
    brt_pkg::t_opcode op;
    brt_pkg::t_rsp    n_rsp;
    brt_pkg::t_rsp    r_rsp;
    logic             n_done;
    logic             r_done;

    // no internal state to wait on, requests are always welcome
    assign busy = 1'b0;

    // byte 0 sits in the low bits of the lo word
    assign blk = {i_req.block_hi, i_req.block_lo};
    assign key = {i_req.key_hi, i_req.key_lo};
    assign op  = brt_pkg::t_opcode'(i_req.opcode);

    // one lane per active byte; bytes past the block length pass straight through
    for (genvar g = 0; g < brt_pkg::MAX_BYTES; g++) begin : g_lane
        if (g < brt_pkg::BLOCK_BYTES) begin : g_act
            // rotate distance cycles 1..7 across byte positions
            localparam logic [2:0] ROT = 3'((g % brt_pkg::ROT_PERIOD) + 1);
            brt_lane u_lane (
                .i_op   (op),
                .i_byte (blk[g]),
                .i_key  (key[g]),
                .i_rot  (ROT),
                .o_byte (lane_out[g])
            );
        end else begin : g_pass
            assign lane_out[g] = blk[g];
        end
    end

    // cross-byte transforms and final selection
    brt_merge u_merge (
        .i_opcode (i_req.opcode),
        .i_orig   (blk),
        .i_lane   (lane_out),
        .o_rsp    (n_rsp)
    );

    assign n_done = start & ~busy;

    // strobe cleared by reset; payload register needs none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // every request produces exactly one strobe on the next cycle
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("result strobe missing after request");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |=> !o_done)
        else $error("result strobe without request");

    // flag tracks the opcode of the request it answers
    a_bad_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.bad_opcode ==
                    ($past(i_req.opcode) > 4'(brt_pkg::OP_INV_DIFFUSE))))
        else $error("bad_opcode does not match request opcode");

    // flagged requests return the block untouched
    a_bad_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.bad_opcode) |->
            (o_rsp.result_lo == $past(i_req.block_lo) &&
             o_rsp.result_hi == $past(i_req.block_hi)))
        else $error("bad opcode did not pass block through");

endmodule

@@ dv/tb.sv @@
// tb: self-checking bench for block_cipher_round_transforms_core, directed then random requests
// depends on brt_pkg and the core; predicts every transform in the bench and checks each result
`timescale 1ns / 1ps

module tb;

    // keeps the expected blocks in request order and checks each result against the oldest
    class round_xform_scoreboard;
        brt_pkg::t_rsp expected_q[$];
        int            mismatches;

        function new();
            mismatches = 0;
        endfunction

        // expected result of one request, byte by byte
        function brt_pkg::t_rsp transform_block(brt_pkg::t_req r);
            brt_pkg::t_blk blk;
            brt_pkg::t_blk key;
            brt_pkg::t_blk orig;
            brt_pkg::t_rsp res;
            int   n;
            int   s;
            n    = brt_pkg::BLOCK_BYTES;
            blk  = {r.block_hi, r.block_lo};
            key  = {r.key_hi, r.key_lo};
            orig = blk;
            res.bad_opcode = 1'b0;
            case (r.opcode)
                brt_pkg::OP_KEY_XOR: begin
                    for (int i = 0; i < n; i++) blk[i] = orig[i] ^ key[i];
                end
                brt_pkg::OP_SBOX: begin
                    for (int i = 0; i < n; i++) begin
                        blk[i] = orig[i] * brt_pkg::SBOX_MUL + brt_pkg::SBOX_ADD;
                    end
                end
                brt_pkg::OP_INV_SBOX: begin
                    for (int i = 0; i < n; i++) begin
                        blk[i] = (orig[i] - brt_pkg::SBOX_ADD) * brt_pkg::INV_SBOX_MUL;
                    end
                end
                brt_pkg::OP_ROTL: begin
                    for (int i = 0; i < n; i++) begin
                        s = (i % brt_pkg::ROT_PERIOD) + 1;
                        blk[i] = (orig[i] << s) | (orig[i] >> (8 - s));
                    end
                end
                brt_pkg::OP_ROTR: begin
                    for (int i = 0; i < n; i++) begin
                        s = (i % brt_pkg::ROT_PERIOD) + 1;
                        blk[i] = (orig[i] >> s) | (orig[i] << (8 - s));
                    end
                end
                brt_pkg::OP_PERM: begin
                    for (int i = 0; i < n; i++) blk[i] = orig[(brt_pkg::PERM_STEP * i) % n];
                end
                brt_pkg::OP_INV_PERM: begin
                    // later writes win, unwritten positions keep the input byte
                    for (int i = 0; i < n; i++) blk[(brt_pkg::PERM_STEP * i) % n] = orig[i];
                end
                brt_pkg::OP_DIFFUSE: begin
                    for (int i = 1; i < n; i++) blk[i] = blk[i] ^ blk[i-1];
                end
                brt_pkg::OP_INV_DIFFUSE: begin
                    for (int i = 1; i < n; i++) blk[i] = orig[i] ^ orig[i-1];
                end
                default: begin
                    res.bad_opcode = 1'b1;
                end
            endcase
            res.result_lo = blk[7:0];
            res.result_hi = blk[15:8];
            return res;
        endfunction

        function void note_request(brt_pkg::t_req r);
            expected_q.push_back(transform_block(r));
        endfunction

        function void check_result(brt_pkg::t_rsp got);
            brt_pkg::t_rsp want;
            bit            wrong;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result lo=%h hi=%h bad=%b",
                             got.result_lo, got.result_hi, got.bad_opcode);
                return;
            end
            want  = expected_q.pop_front();
            wrong = (got.result_lo !== want.result_lo) ||
                    (got.result_hi !== want.result_hi) ||
                    (got.bad_opcode !== want.bad_opcode);
            if (wrong) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch at %0t: expected lo=%h hi=%h bad=%b, ",
                              "got lo=%h hi=%h bad=%b"},
                             $realtime, want.result_lo, want.result_hi, want.bad_opcode,
                             got.result_lo, got.result_hi, got.bad_opcode);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    brt_pkg::t_req req;
    logic          busy;
    logic          o_done;
    brt_pkg::t_rsp o_rsp;

    round_xform_scoreboard sb;

    block_cipher_round_transforms_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #400us;
        $display("FAIL");
        $finish;
    end

    // results cannot be held off, so every strobe is checked on the edge that ends it
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_result(o_rsp);
        end
    end

    // 64-bit word, sometimes built from all-zero and all-one bytes
    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        if ($urandom_range(3) == 0) begin
            for (int i = 0; i < 8; i++) begin
                case ($urandom_range(2))
                    0: w[8*i +: 8] = 8'h00;
                    1: w[8*i +: 8] = 8'hff;
                    default: ;
                endcase
            end
        end
        return w;
    endfunction

    function automatic brt_pkg::t_req make_request(logic [3:0] op,
                                                   logic [63:0] blo, logic [63:0] bhi,
                                                   logic [63:0] klo, logic [63:0] khi);
        brt_pkg::t_req r;
        r.opcode   = op;
        r.block_lo = blo;
        r.block_hi = bhi;
        r.key_lo   = klo;
        r.key_hi   = khi;
        return r;
    endfunction

    // hold the request until the core takes it
    task automatic send_request(brt_pkg::t_req r);
        start <= 1'b1;
        req   <= r;
        do @(posedge i_clk); while (busy);
        sb.note_request(r);
    endtask

    // start low with junk on the request bus, which the core must ignore
    task automatic idle_cycles(int cycles);
        start <= 1'b0;
        req   <= make_request(4'($urandom), rand_word(), rand_word(), rand_word(), rand_word());
        repeat (cycles) @(posedge i_clk);
    endtask

    // single idle cycle now and then, on about 16 calls in a hundred
    task automatic maybe_idle(bit allow);
        if (allow && $urandom_range(99) < 16) idle_cycles(1);
    endtask

    task automatic run_directed();
        brt_pkg::t_req r;
        // every opcode, bad ones included, on random data
        for (int op = 0; op < 16; op++) begin
            r = make_request(4'(op), rand_word(), rand_word(), rand_word(), rand_word());
            send_request(r);
            maybe_idle(1'b1);
        end
        // extremes of block and key
        send_request(make_request(brt_pkg::OP_KEY_XOR, '0, '0, '1, '1));
        send_request(make_request(brt_pkg::OP_KEY_XOR, '1, '1, '1, '1));
        send_request(make_request(brt_pkg::OP_SBOX, '0, '0, '0, '0));
        send_request(make_request(brt_pkg::OP_INV_SBOX, '1, '1, '0, '0));
        send_request(make_request(brt_pkg::OP_DIFFUSE, '1, '1, '0, '0));
        send_request(make_request(brt_pkg::OP_INV_DIFFUSE, 64'h0123456789abcdef,
                                  64'hfedcba9876543210, '0, '0));
        send_request(make_request(4'd15, '1, '0, '1, '0));
    endtask

    task automatic run_random(int count);
        brt_pkg::t_req r;
        logic [3:0]    op;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 85) op = 4'($urandom_range(8));
            else                         op = 4'($urandom_range(15, 9));
            r = make_request(op, rand_word(), rand_word(), rand_word(), rand_word());
            // back-to-back stretch with no gaps
            maybe_idle(!(n >= 400 && n < 600));
            if (n == 800) begin
                // drain everything before going on
                start <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
            end
            send_request(r);
        end
    endtask

    initial begin
        int guard;
        sb = new();
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        req     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random(1100);
        start <= 1'b0;

        guard = 0;
        while (sb.pending() != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        // leave room for stray strobes after the last result
        repeat (8) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
